@@ src/ffs_pkg.sv @@
// Shared constants, register codes and types of the flow frame statistics block.
package ffs_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W      = $clog2(MAX_DIM + 1);
  localparam int PIX_W      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  localparam int CFG_DIM_W  = 9;
  localparam int CHAN_W     = 8;
  localparam int SCALE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int RES_W      = 32;

  // |value - zero_point| < 2^8, so a signed sum needs PIX_W + 9 bits
  localparam int SUM_W      = PIX_W + CHAN_W + 1;
  localparam int PROD_W     = SUM_W + SCALE_W - FRAC_W;
  localparam int STEP_W     = $clog2(PROD_W);

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = CFG_DIM_W'(256);
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = CFG_DIM_W'(256);
  localparam logic [SCALE_W-1:0]   SCALE_RST  = SCALE_W'(65536000);

  localparam logic signed [CHAN_W-1:0] CHAN_MAX = CHAN_W'(127);
  localparam logic signed [CHAN_W-1:0] CHAN_MIN = -CHAN_W'(128);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ZERO_POINT   = 2'd2,
    REG_SCALE        = 2'd3
  } cfg_reg_e;

  // Frame totals taken on the last pixel of a frame
  typedef struct packed {
    logic signed [SUM_W-1:0]  sum_first;
    logic signed [SUM_W-1:0]  sum_second;
    logic signed [CHAN_W-1:0] min_first;
    logic signed [CHAN_W-1:0] max_first;
    logic signed [CHAN_W-1:0] min_second;
    logic signed [CHAN_W-1:0] max_second;
    logic signed [CHAN_W-1:0] center_first;
    logic signed [CHAN_W-1:0] center_second;
    logic [PIX_W-1:0]         pixels;
  } ffs_snap_t;

endpackage

@@ src/ffs_accum.sv @@
// Per-pixel accumulation: sums, extremes, centre capture and frame end detect.
module ffs_accum (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 fire_i,
  input  logic signed [ffs_pkg::CHAN_W-1:0]    first_i,
  input  logic signed [ffs_pkg::CHAN_W-1:0]    second_i,
  input  logic [ffs_pkg::CFG_DIM_W-1:0]        width_i,
  input  logic [ffs_pkg::CFG_DIM_W-1:0]        height_i,
  input  logic signed [ffs_pkg::CHAN_W-1:0]    zero_point_i,
  output logic                                 frame_end_o,
  output ffs_pkg::ffs_snap_t                   snap_o
);

  logic [ffs_pkg::DIM_W-1:0]              w_eff, h_eff;
  logic [ffs_pkg::PIX_W-1:0]              pixels, centre;
  logic [ffs_pkg::PIX_W-1:0]              count_q, count_d;
  logic [ffs_pkg::PIX_W:0]                count_inc;
  logic signed [ffs_pkg::SUM_W-1:0]       sum_first_q, sum_second_q;
  logic signed [ffs_pkg::SUM_W-1:0]       term_first, term_second;
  logic signed [ffs_pkg::CHAN_W-1:0]      min_first_q, max_first_q;
  logic signed [ffs_pkg::CHAN_W-1:0]      min_second_q, max_second_q;
  logic signed [ffs_pkg::CHAN_W-1:0]      ctr_first_q, ctr_second_q;
  logic                                   hit;

  // Clamp the frame size: zero counts as one, oversize as the maximum
  always_comb begin
    if (width_i == '0) begin
      w_eff = ffs_pkg::DIM_W'(1);
    end else if (int'(width_i) > ffs_pkg::MAX_WIDTH) begin
      w_eff = ffs_pkg::DIM_W'(ffs_pkg::MAX_WIDTH);
    end else begin
      w_eff = ffs_pkg::DIM_W'(width_i);
    end
    if (height_i == '0) begin
      h_eff = ffs_pkg::DIM_W'(1);
    end else if (int'(height_i) > ffs_pkg::MAX_HEIGHT) begin
      h_eff = ffs_pkg::DIM_W'(ffs_pkg::MAX_HEIGHT);
    end else begin
      h_eff = ffs_pkg::DIM_W'(height_i);
    end
  end

  assign pixels    = ffs_pkg::PIX_W'(w_eff) * ffs_pkg::PIX_W'(h_eff);
  assign centre    = ffs_pkg::PIX_W'(h_eff >> 1) * ffs_pkg::PIX_W'(w_eff)
                   + ffs_pkg::PIX_W'(w_eff >> 1);
  assign hit       = (count_q == centre);
  assign count_inc = {1'b0, count_q} + (ffs_pkg::PIX_W + 1)'(1);
  assign count_d   = count_inc[ffs_pkg::PIX_W-1:0];

  assign term_first  = ffs_pkg::SUM_W'(first_i) - ffs_pkg::SUM_W'(zero_point_i);
  assign term_second = ffs_pkg::SUM_W'(second_i) - ffs_pkg::SUM_W'(zero_point_i);

  assign frame_end_o = fire_i && (count_inc >= {1'b0, pixels});

  // Totals including the pixel now being taken
  always_comb begin
    snap_o.sum_first     = sum_first_q + term_first;
    snap_o.sum_second    = sum_second_q + term_second;
    snap_o.min_first     = (first_i < min_first_q) ? first_i : min_first_q;
    snap_o.max_first     = (first_i > max_first_q) ? first_i : max_first_q;
    snap_o.min_second    = (second_i < min_second_q) ? second_i : min_second_q;
    snap_o.max_second    = (second_i > max_second_q) ? second_i : max_second_q;
    snap_o.center_first  = hit ? first_i : ctr_first_q;
    snap_o.center_second = hit ? second_i : ctr_second_q;
    snap_o.pixels        = pixels;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      sum_first_q  <= '0;
      sum_second_q <= '0;
      min_first_q  <= ffs_pkg::CHAN_MAX;
      max_first_q  <= ffs_pkg::CHAN_MIN;
      min_second_q <= ffs_pkg::CHAN_MAX;
      max_second_q <= ffs_pkg::CHAN_MIN;
      ctr_first_q  <= '0;
      ctr_second_q <= '0;
    end else if (frame_end_o) begin
      count_q      <= '0;
      sum_first_q  <= '0;
      sum_second_q <= '0;
      min_first_q  <= ffs_pkg::CHAN_MAX;
      max_first_q  <= ffs_pkg::CHAN_MIN;
      min_second_q <= ffs_pkg::CHAN_MAX;
      max_second_q <= ffs_pkg::CHAN_MIN;
      ctr_first_q  <= '0;
      ctr_second_q <= '0;
    end else if (fire_i) begin
      count_q      <= count_d;
      sum_first_q  <= snap_o.sum_first;
      sum_second_q <= snap_o.sum_second;
      min_first_q  <= snap_o.min_first;
      max_first_q  <= snap_o.max_first;
      min_second_q <= snap_o.min_second;
      max_second_q <= snap_o.max_second;
      ctr_first_q  <= snap_o.center_first;
      ctr_second_q <= snap_o.center_second;
    end
  end

endmodule

@@ src/ffs_scale_div.sv @@
// Shared scale-and-divide unit: one multiply, then a bit-serial restoring divide.
module ffs_scale_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [ffs_pkg::SUM_W-1:0]    num_i,
  input  logic [ffs_pkg::PIX_W-1:0]           den_i,
  input  logic [ffs_pkg::SCALE_W-1:0]         scale_i,
  output logic                                done_o,
  output logic signed [ffs_pkg::RES_W-1:0]    result_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_DIV,
    D_FIN
  } div_state_e;

  div_state_e                                   state_q;
  logic                                         neg_q;
  logic [ffs_pkg::PROD_W-1:0]                   quo_q;
  logic [ffs_pkg::PIX_W-1:0]                    rem_q, den_q;
  logic [ffs_pkg::STEP_W-1:0]                   step_q;
  logic [ffs_pkg::SUM_W-1:0]                    mag;
  logic [ffs_pkg::SUM_W+ffs_pkg::SCALE_W-1:0]   prod_full;
  logic [ffs_pkg::PIX_W:0]                      trial;
  logic                                         take;
  logic [ffs_pkg::PIX_W-1:0]                    rem_d;
  logic                                         over;

  assign mag       = num_i[ffs_pkg::SUM_W-1] ? ffs_pkg::SUM_W'(-num_i)
                                             : ffs_pkg::SUM_W'(num_i);
  assign prod_full = mag * scale_i;

  // One quotient bit per cycle
  assign trial = {rem_q, quo_q[ffs_pkg::PROD_W-1]};
  assign take  = (trial >= {1'b0, den_q});
  always_comb begin
    if (take) begin
      rem_d = ffs_pkg::PIX_W'(trial - {1'b0, den_q});
    end else begin
      rem_d = trial[ffs_pkg::PIX_W-1:0];
    end
  end

  // Saturate the signed quotient to the result width
  assign over = (quo_q[ffs_pkg::PROD_W-1:ffs_pkg::RES_W-1] != '0);
  always_comb begin
    if (neg_q) begin
      result_o = over ? {1'b1, {(ffs_pkg::RES_W-1){1'b0}}}
                      : -$signed(quo_q[ffs_pkg::RES_W-1:0]);
    end else begin
      result_o = over ? {1'b0, {(ffs_pkg::RES_W-1){1'b1}}}
                      : $signed(quo_q[ffs_pkg::RES_W-1:0]);
    end
  end

  assign done_o = (state_q == D_FIN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            step_q  <= '0;
            state_q <= D_DIV;
          end
        end
        D_DIV: begin
          step_q <= step_q + ffs_pkg::STEP_W'(1);
          if (step_q == ffs_pkg::STEP_W'(ffs_pkg::PROD_W - 1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          state_q <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  // Datapath: load the scaled magnitude, then shift the quotient in
  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      neg_q <= num_i[ffs_pkg::SUM_W-1];
      quo_q <= prod_full[ffs_pkg::SUM_W+ffs_pkg::SCALE_W-1:ffs_pkg::FRAC_W];
      rem_q <= '0;
      den_q <= den_i;
    end else if (state_q == D_DIV) begin
      quo_q <= {quo_q[ffs_pkg::PROD_W-2:0], take};
      rem_q <= rem_d;
    end
  end

endmodule

@@ src/flow_frame_statistics_unit.sv @@
// Top level of the flow frame statistics block: config registers, sequencer, result word.
//
// Takes one flow pixel word (channel 0 and channel 1, signed 8 bit) per cycle
// while in_ready_o is high, in raster order, and keeps per-frame sums of
// (value - zero_point), minima, maxima and the centre pixel at
// (height/2)*width + width/2. The pixel that brings the count to width*height
// closes the frame; the block then drops in_ready_o and runs four scaled
// divisions on one shared multiply/restoring-divide unit (centre first, centre
// second, mean first, mean second) before the result word is loaded. The
// result word waits in an output register; in_ready_o stays low from the last
// pixel of a frame until its result word is loaded, so every frame end stalls
// the input; the stall lasts longer while the previous result word is untaken.
// The centre and mean outputs are value * scale / 65536 (mean: divided by the
// pixel count), truncated toward zero and saturated to 32 bits. Width and height
// of 0 count as 1, larger than the maximum count as the maximum. Write the
// registers only while no frame is in flight.
module flow_frame_statistics_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 cfg_we_i,
  input  logic [ffs_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [ffs_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,

  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [ffs_pkg::CHAN_W-1:0]    first_channel_i,
  input  logic signed [ffs_pkg::CHAN_W-1:0]    second_channel_i,

  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [ffs_pkg::RES_W-1:0]     center_first_milli_o,
  output logic signed [ffs_pkg::RES_W-1:0]     center_second_milli_o,
  output logic signed [ffs_pkg::RES_W-1:0]     mean_first_milli_o,
  output logic signed [ffs_pkg::RES_W-1:0]     mean_second_milli_o,
  output logic signed [ffs_pkg::CHAN_W-1:0]    first_min_o,
  output logic signed [ffs_pkg::CHAN_W-1:0]    first_max_o,
  output logic signed [ffs_pkg::CHAN_W-1:0]    second_min_o,
  output logic signed [ffs_pkg::CHAN_W-1:0]    second_max_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_HOLD
  } seq_state_e;

  typedef enum logic [1:0] {
    OP_CTR_FIRST  = 2'd0,
    OP_CTR_SECOND = 2'd1,
    OP_MEAN_FIRST = 2'd2,
    OP_MEAN_SECOND = 2'd3
  } op_e;

  // Configuration registers
  logic [ffs_pkg::CFG_DIM_W-1:0]       width_q, height_q;
  logic signed [ffs_pkg::CHAN_W-1:0]   zero_point_q;
  logic [ffs_pkg::SCALE_W-1:0]         scale_q;

  // Sequencer
  seq_state_e                          state_q;
  op_e                                 op_q;
  logic                                start_q;
  logic                                out_valid_q;
  logic                                out_free;

  // Frame snapshot and staged results
  ffs_pkg::ffs_snap_t                  snap, snap_q;
  logic                                frame_end, in_fire;
  logic signed [ffs_pkg::RES_W-1:0]    res_q [4];

  // Shared unit operands
  logic signed [ffs_pkg::SUM_W-1:0]    num;
  logic [ffs_pkg::PIX_W-1:0]           den;
  logic signed [ffs_pkg::CHAN_W:0]     ctr_diff;
  logic                                div_done;
  logic signed [ffs_pkg::RES_W-1:0]    div_result;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= ffs_pkg::WIDTH_RST;
      height_q     <= ffs_pkg::HEIGHT_RST;
      zero_point_q <= '0;
      scale_q      <= ffs_pkg::SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (ffs_pkg::cfg_reg_e'(cfg_addr_i))
        ffs_pkg::REG_FRAME_WIDTH:  width_q      <= cfg_wdata_i[ffs_pkg::CFG_DIM_W-1:0];
        ffs_pkg::REG_FRAME_HEIGHT: height_q     <= cfg_wdata_i[ffs_pkg::CFG_DIM_W-1:0];
        ffs_pkg::REG_ZERO_POINT:   zero_point_q <= $signed(cfg_wdata_i[ffs_pkg::CHAN_W-1:0]);
        ffs_pkg::REG_SCALE:        scale_q      <= cfg_wdata_i[ffs_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  ffs_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .first_i      (first_channel_i),
    .second_i     (second_channel_i),
    .width_i      (width_q),
    .height_i     (height_q),
    .zero_point_i (zero_point_q),
    .frame_end_o  (frame_end),
    .snap_o       (snap)
  );

  // Pick the operands of the current operation; centre terms divide by one
  always_comb begin
    ctr_diff = '0;
    num      = '0;
    den      = ffs_pkg::PIX_W'(1);
    unique case (op_q)
      OP_CTR_FIRST: begin
        ctr_diff = (ffs_pkg::CHAN_W + 1)'(snap_q.center_first)
                 - (ffs_pkg::CHAN_W + 1)'(zero_point_q);
        num      = ffs_pkg::SUM_W'(ctr_diff);
      end
      OP_CTR_SECOND: begin
        ctr_diff = (ffs_pkg::CHAN_W + 1)'(snap_q.center_second)
                 - (ffs_pkg::CHAN_W + 1)'(zero_point_q);
        num      = ffs_pkg::SUM_W'(ctr_diff);
      end
      OP_MEAN_FIRST: begin
        num = snap_q.sum_first;
        den = snap_q.pixels;
      end
      OP_MEAN_SECOND: begin
        num = snap_q.sum_second;
        den = snap_q.pixels;
      end
      default: ;
    endcase
  end

  ffs_scale_div u_scale_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_q),
    .num_i    (num),
    .den_i    (den),
    .scale_i  (scale_q),
    .done_o   (div_done),
    .result_o (div_result)
  );

  // Sequencer: snapshot on frame end, run four operations, hand over the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_CTR_FIRST;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop valid once the word is taken; the hold state reloads it itself
      if (out_valid_q && out_ready_i && state_q != S_HOLD) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          start_q <= frame_end;
          if (frame_end) begin
            op_q    <= OP_CTR_FIRST;
            state_q <= S_CALC;
          end
        end
        S_CALC: begin
          start_q <= div_done && (op_q != OP_MEAN_SECOND);
          if (div_done) begin
            if (op_q == OP_MEAN_SECOND) begin
              state_q <= S_HOLD;
            end else begin
              op_q <= op_e'(op_q + 2'd1);
            end
          end
        end
        S_HOLD: begin
          start_q <= 1'b0;
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          start_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: snapshot, staged results and the output word
  always_ff @(posedge clk_i) begin
    if (frame_end) begin
      snap_q <= snap;
    end
    if (state_q == S_CALC && div_done) begin
      res_q[op_q] <= div_result;
    end
    if (state_q == S_HOLD && out_free) begin
      center_first_milli_o  <= res_q[OP_CTR_FIRST];
      center_second_milli_o <= res_q[OP_CTR_SECOND];
      mean_first_milli_o    <= res_q[OP_MEAN_FIRST];
      mean_second_milli_o   <= res_q[OP_MEAN_SECOND];
      first_min_o           <= snap_q.min_first;
      first_max_o           <= snap_q.max_first;
      second_min_o          <= snap_q.min_second;
      second_max_o          <= snap_q.max_second;
    end
  end

endmodule

@@ sim/frame_stats_checker.sv @@
// Checker for the flow frame statistics block: predicts each frame result and compares it.
module frame_stats_checker
  import ffs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [CHAN_W-1:0] first_channel_i,
  input  logic signed [CHAN_W-1:0] second_channel_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [RES_W-1:0]  center_first_milli_i,
  input  logic signed [RES_W-1:0]  center_second_milli_i,
  input  logic signed [RES_W-1:0]  mean_first_milli_i,
  input  logic signed [RES_W-1:0]  mean_second_milli_i,
  input  logic signed [CHAN_W-1:0] first_min_i,
  input  logic signed [CHAN_W-1:0] first_max_i,
  input  logic signed [CHAN_W-1:0] second_min_i,
  input  logic signed [CHAN_W-1:0] second_max_i,
  output int                       results_due_o,
  output int                       failures_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [RES_W-1:0]  center_first;
    logic signed [RES_W-1:0]  center_second;
    logic signed [RES_W-1:0]  mean_first;
    logic signed [RES_W-1:0]  mean_second;
    logic signed [CHAN_W-1:0] first_min;
    logic signed [CHAN_W-1:0] first_max;
    logic signed [CHAN_W-1:0] second_min;
    logic signed [CHAN_W-1:0] second_max;
  } frame_stats_t;

  localparam int REPORT_LIMIT = 10;

  // register copy
  logic [CFG_DIM_W-1:0]     width_cfg;
  logic [CFG_DIM_W-1:0]     height_cfg;
  logic signed [CHAN_W-1:0] zero_point_cfg;
  logic [SCALE_W-1:0]       scale_cfg;

  // running frame totals
  int                       seen_pixels;
  longint                   sum_first;
  longint                   sum_second;
  logic signed [CHAN_W-1:0] lo_first, hi_first, lo_second, hi_second;
  logic signed [CHAN_W-1:0] mid_first, mid_second;

  frame_stats_t stats_due[$];

  function automatic int clamped_dim(logic [CFG_DIM_W-1:0] v, int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  // |num| * scale / (den * 2^16), sign of num, truncated toward zero, saturated
  function automatic logic [RES_W-1:0] milli_ratio(longint num, int den,
                                                   logic [SCALE_W-1:0] scale);
    longint unsigned mag, divisor, quo, rem, prod;
    logic [RES_W-1:0] low;
    mag = (num < 0) ? -num : num;
    divisor = den;
    quo = mag / divisor;
    rem = mag % divisor;
    prod = quo * scale + (rem * scale) / divisor;
    prod = prod >> FRAC_W;
    low = prod[RES_W-1:0];
    if (num < 0) begin
      if (prod >= 64'h8000_0000) return 32'h8000_0000;
      return -low;
    end
    if (prod > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return low;
  endfunction

  function automatic string stats_text(frame_stats_t s);
    return $sformatf("c=(%0d,%0d) m=(%0d,%0d) first=[%0d,%0d] second=[%0d,%0d]",
                     $signed(s.center_first), $signed(s.center_second),
                     $signed(s.mean_first), $signed(s.mean_second),
                     $signed(s.first_min), $signed(s.first_max),
                     $signed(s.second_min), $signed(s.second_max));
  endfunction

  task automatic clear_frame();
    seen_pixels = 0;
    sum_first   = 0;
    sum_second  = 0;
    lo_first    = CHAN_MAX;
    hi_first    = CHAN_MIN;
    lo_second   = CHAN_MAX;
    hi_second   = CHAN_MIN;
    mid_first   = '0;
    mid_second  = '0;
  endtask

  task automatic report_failure(string msg);
    failures_o++;
    if (failures_o <= REPORT_LIMIT) $display("%t: %s", $realtime, msg);
  endtask

  task automatic take_pixel(logic signed [CHAN_W-1:0] a, logic signed [CHAN_W-1:0] b);
    int w, h, frame_len, centre_idx;
    frame_stats_t done;
    w = clamped_dim(width_cfg, MAX_WIDTH);
    h = clamped_dim(height_cfg, MAX_HEIGHT);
    frame_len  = w * h;
    centre_idx = (h / 2) * w + w / 2;
    if (seen_pixels == centre_idx) begin
      mid_first  = a;
      mid_second = b;
    end
    sum_first  += longint'(a) - longint'(zero_point_cfg);
    sum_second += longint'(b) - longint'(zero_point_cfg);
    if (a < lo_first)  lo_first  = a;
    if (a > hi_first)  hi_first  = a;
    if (b < lo_second) lo_second = b;
    if (b > hi_second) hi_second = b;
    seen_pixels++;
    if (seen_pixels >= frame_len) begin
      done.center_first  = milli_ratio(longint'(mid_first) - longint'(zero_point_cfg), 1,
                                       scale_cfg);
      done.center_second = milli_ratio(longint'(mid_second) - longint'(zero_point_cfg), 1,
                                       scale_cfg);
      done.mean_first    = milli_ratio(sum_first, frame_len, scale_cfg);
      done.mean_second   = milli_ratio(sum_second, frame_len, scale_cfg);
      done.first_min     = lo_first;
      done.first_max     = hi_first;
      done.second_min    = lo_second;
      done.second_max    = hi_second;
      stats_due.push_back(done);
      clear_frame();
    end
  endtask

  task automatic check_result();
    frame_stats_t got, want;
    got.center_first  = center_first_milli_i;
    got.center_second = center_second_milli_i;
    got.mean_first    = mean_first_milli_i;
    got.mean_second   = mean_second_milli_i;
    got.first_min     = first_min_i;
    got.first_max     = first_max_i;
    got.second_min    = second_min_i;
    got.second_max    = second_max_i;
    if (stats_due.size() == 0) begin
      report_failure({"unexpected result word: ", stats_text(got)});
    end else begin
      want = stats_due.pop_front();
      if (got !== want)
        report_failure({"result mismatch: expected ", stats_text(want),
                        " got ", stats_text(got)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg      = WIDTH_RST;
      height_cfg     = HEIGHT_RST;
      zero_point_cfg = '0;
      scale_cfg      = SCALE_RST;
      clear_frame();
      stats_due.delete();
      results_due_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_FRAME_WIDTH:  width_cfg      = cfg_wdata_i[CFG_DIM_W-1:0];
          REG_FRAME_HEIGHT: height_cfg     = cfg_wdata_i[CFG_DIM_W-1:0];
          REG_ZERO_POINT:   zero_point_cfg = cfg_wdata_i[CHAN_W-1:0];
          REG_SCALE:        scale_cfg      = cfg_wdata_i[SCALE_W-1:0];
        endcase
      end
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) take_pixel(first_channel_i, second_channel_i);
      results_due_o = stats_due.size();
    end
  end

endmodule

@@ sim/testbench.sv @@
// Top of the flow frame statistics testbench: stimulus, flow control, watchdog and verdict.
module testbench;
  import ffs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET    = 650;
  localparam int QUIET_CYCLES   = 200;
  localparam int RX_HOLD_CYCLES = 600;   // long enough to back up the input
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SMALL_PHASE    = 24;    // at most this many pixel words per phase with small frames

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_ADDR_W-1:0]    cfg_addr;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [CHAN_W-1:0] first_chan;
  logic signed [CHAN_W-1:0] second_chan;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [RES_W-1:0]  center_first_milli;
  logic signed [RES_W-1:0]  center_second_milli;
  logic signed [RES_W-1:0]  mean_first_milli;
  logic signed [RES_W-1:0]  mean_second_milli;
  logic signed [CHAN_W-1:0] first_min;
  logic signed [CHAN_W-1:0] first_max;
  logic signed [CHAN_W-1:0] second_min;
  logic signed [CHAN_W-1:0] second_max;

  int results_due;
  int failures;

  // flow control knobs, percent of cycles spent idle on each side
  int tx_idle_pct = 33;
  int rx_idle_pct = 56;
  logic rx_hold_req;

  int pixels_sent;
  int stall_cycles;

  flow_frame_statistics_unit DUT (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_addr_i            (cfg_addr),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .first_channel_i       (first_chan),
    .second_channel_i      (second_chan),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .center_first_milli_o  (center_first_milli),
    .center_second_milli_o (center_second_milli),
    .mean_first_milli_o    (mean_first_milli),
    .mean_second_milli_o   (mean_second_milli),
    .first_min_o           (first_min),
    .first_max_o           (first_max),
    .second_min_o          (second_min),
    .second_max_o          (second_max)
  );

  frame_stats_checker u_checker (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_we_i              (cfg_we),
    .cfg_addr_i            (cfg_addr),
    .cfg_wdata_i           (cfg_wdata),
    .in_valid_i            (in_valid),
    .in_ready_i            (in_ready),
    .first_channel_i       (first_chan),
    .second_channel_i      (second_chan),
    .out_valid_i           (out_valid),
    .out_ready_i           (out_ready),
    .center_first_milli_i  (center_first_milli),
    .center_second_milli_i (center_second_milli),
    .mean_first_milli_i    (mean_first_milli),
    .mean_second_milli_i   (mean_second_milli),
    .first_min_i           (first_min),
    .first_max_i           (first_max),
    .second_min_i          (second_min),
    .second_max_i          (second_max),
    .results_due_o         (results_due),
    .failures_o            (failures)
  );

  // 10 ns clock, low phase first
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Pick a channel value, leaning on the two extremes now and then.
  function automatic logic signed [CHAN_W-1:0] flow_value();
    case ($urandom_range(9))
      0:       return CHAN_MAX;
      1:       return CHAN_MIN;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // Offer one pixel word and hold it until taken. Enter and leave at a falling edge;
  // valid stays high on return so a back-to-back word needs no extra step.
  task automatic push_pixel(logic signed [CHAN_W-1:0] a, logic signed [CHAN_W-1:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    first_chan  <= a;
    second_chan <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    pixels_sent++;
  endtask

  // Write one register and return at a falling edge; the enable stays high for the next write.
  task automatic drive_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  // Write the whole register set; only call while the block is idle.
  task automatic configure(int w, int h, int zp, logic [SCALE_W-1:0] scale);
    drive_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    drive_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    drive_reg(REG_ZERO_POINT, CFG_DATA_W'(zp));
    drive_reg(REG_SCALE, scale);
    cfg_we <= 1'b0;
  endtask

  // Drop valid, wait for every frame result to drain, then let the divider go quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Receiver: random ready, with an occasional long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("flow_frame_statistics_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int phase, w, h, zp, pix, frames, saved_tx;
    logic [SCALE_W-1:0] scale;

    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = REG_FRAME_WIDTH;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    first_chan  = '0;
    second_chan = '0;
    rx_hold_req = 1'b0;
    pixels_sent = 0;
    stall_cycles = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // 3x3 frame at unit scale: both extremes on each channel, centre at index 4
    configure(3, 3, 0, 32'd65536000);
    push_pixel(CHAN_MAX, CHAN_MIN);
    push_pixel(CHAN_MIN, CHAN_MAX);
    push_pixel(8'sd0, 8'sd0);
    push_pixel(-8'sd1, 8'sd1);
    push_pixel(8'sd100, -8'sd100);
    push_pixel(8'sd1, -8'sd1);
    push_pixel(CHAN_MIN, CHAN_MIN);
    push_pixel(CHAN_MAX, CHAN_MAX);
    push_pixel(8'sd5, -8'sd5);
    settle();

    // zero width and height count as one: every word closes a frame; top zero point
    // and the largest scale
    configure(0, 0, 127, 32'hFFFF_FFFF);
    push_pixel(CHAN_MIN, CHAN_MIN);
    push_pixel(CHAN_MAX, CHAN_MAX);
    settle();

    // single column, bottom zero point, zero scale
    configure(1, 4, -128, '0);
    push_pixel(CHAN_MAX, 8'sd0);
    push_pixel(8'sd0, CHAN_MIN);
    push_pixel(-8'sd7, 8'sd3);
    push_pixel(8'sd9, -8'sd2);
    settle();

    // single row, smallest nonzero scale: means truncate toward zero
    configure(4, 1, 5, 32'd1);
    push_pixel(-8'sd3, 8'sd7);
    push_pixel(-8'sd20, 8'sd60);
    push_pixel(8'sd4, -8'sd1);
    push_pixel(CHAN_MIN, CHAN_MAX);
    settle();

    // Random phases. The sender waits for every result before each new setting.
    phase = 0;
    while (pixels_sent < ITEM_TARGET || phase < 9) begin
      if (pixels_sent < ITEM_TARGET / 3) begin
        tx_idle_pct = 33;
        rx_idle_pct = 56;
      end else if (pixels_sent < 2 * ITEM_TARGET / 3) begin
        tx_idle_pct = 56;
        rx_idle_pct = 33;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      if ($urandom_range(3) == 0) zp = $urandom_range(1) ? 127 : -128;
      else zp = int'($urandom_range(255)) - 128;
      case ($urandom_range(5))
        0:       scale = '0;
        1:       scale = 32'hFFFF_FFFF;
        2:       scale = 32'd65536000;
        default: scale = $urandom;
      endcase

      if (phase == 4) begin
        w = 511;   // clamps to the widest row
        h = 0;
      end else if (phase == 7) begin
        w = 1;
        h = 511;   // clamps to the tallest column
      end else begin
        w = $urandom_range(7);
        h = $urandom_range(7);
      end
      pix = ((w == 0) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w) *
            ((h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h);

      if (phase == 2) begin
        // Back-pressure: one-pixel frames stream in while the receiver holds off,
        // so the result register and divider fill and in_ready drops.
        configure(1, 1, zp, scale);
        saved_tx = tx_idle_pct;
        tx_idle_pct = 0;
        rx_hold_req = 1'b1;
        repeat (12) push_pixel(flow_value(), flow_value());
        tx_idle_pct = saved_tx;
      end else begin
        configure(w, h, zp, scale);
        frames = (pix >= SMALL_PHASE) ? 1 : SMALL_PHASE / pix;
        repeat (frames * pix) push_pixel(flow_value(), flow_value());
      end
      settle();
      phase++;
    end

    if (failures == 0 && results_due == 0) begin
      $display("flow_frame_statistics_unit regression: pass");
    end else begin
      $display("flow_frame_statistics_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/ffs_pkg.sv
src/ffs_accum.sv
src/ffs_scale_div.sv
src/flow_frame_statistics_unit.sv
sim/frame_stats_checker.sv
sim/testbench.sv
